[design/aet_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aet_pkg
// Types, constants and the cosine table builder of the envelope/tremolo block.
// ----------------------------------------------------------------------------
package aet_pkg;

    localparam int TIME_W    = 24;
    localparam int TDATA_W   = 24;
    localparam int AMP_OUT_W = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int PUNCH_W   = 16;
    localparam int DEPTH_W   = 17;
    localparam int RATE_W    = 20;

    localparam int COS_TABLE_DEPTH = 1024;
    localparam int COS_AW          = $clog2(COS_TABLE_DEPTH);
    localparam int COS_CW          = $clog2(COS_TABLE_DEPTH + 1);
    localparam int COS_W           = 17;
    localparam int PHASE_W         = 26;

    // divider: 40-bit dividend, 24-bit divisor, one quotient bit a stage
    localparam int NUM_W     = 40;
    localparam int DVS_W     = 24;
    localparam int DIV_STEPS = NUM_W;
    localparam int QUO_W     = 36;
    localparam int AMP_W     = 38;
    localparam int GAIN_W    = 18;
    localparam int PSUM_W    = 34;
    localparam int PRODG_W   = AMP_W + GAIN_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PUNCH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RATE    = 3'd5;

    // envelope segment codes
    localparam logic [1:0] SEG_ATTACK  = 2'd0;
    localparam logic [1:0] SEG_SUSTAIN = 2'd1;
    localparam logic [1:0] SEG_DECAY   = 2'd2;
    localparam logic [1:0] SEG_ZERO    = 2'd3;

    typedef struct packed {
        logic [1:0]               seg;
        logic [DVS_W-1:0]         rem;
        logic [NUM_W-1:0]         nq;
        logic [DVS_W-1:0]         dvs;
        logic [PHASE_W-1:0]       phase;
        logic [COS_AW-1:0]        k;
        logic signed [GAIN_W-1:0] g;
    } aet_stage_t;

    typedef struct packed {
        logic [DVS_W-1:0] rem;
        logic [NUM_W-1:0] nq;
    } aet_div_t;

    typedef logic [COS_W-1:0] aet_cos_table_t [COS_TABLE_DEPTH];

    // one restoring step: shift a dividend bit in, subtract when it fits
    function automatic aet_div_t div_step(input logic [DVS_W-1:0] rem,
                                          input logic [NUM_W-1:0] nq,
                                          input logic [DVS_W-1:0] dvs);
        logic [DVS_W:0] r;
        logic           qb;
        aet_div_t       o;
        r  = {rem, nq[NUM_W-1]};
        qb = (r >= {1'b0, dvs});
        if (qb) begin
            r = r - {1'b0, dvs};
        end
        o.rem = r[DVS_W-1:0];
        o.nq  = {nq[NUM_W-2:0], qb};
        return o;
    endfunction

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint Q30_HALF_PI = 64'sd1686629713;

    // divide a series term by (n+1)*(n+2) for the term order n
    function automatic longint unsigned series_div(input longint unsigned v, input int n);
        longint unsigned q;
        case (n)
            0:       q = v / 64'd2;
            1:       q = v / 64'd6;
            2:       q = v / 64'd12;
            3:       q = v / 64'd20;
            4:       q = v / 64'd30;
            5:       q = v / 64'd42;
            6:       q = v / 64'd56;
            7:       q = v / 64'd72;
            8:       q = v / 64'd90;
            9:       q = v / 64'd110;
            10:      q = v / 64'd132;
            11:      q = v / 64'd156;
            12:      q = v / 64'd182;
            default: q = v / 64'd210;
        endcase
        return q;
    endfunction

    // Q30 Taylor series on a quarter wave; odd selects sine
    function automatic longint taylor(input longint x, input bit odd);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        int              n;
        x2   = (longint'(x) * longint'(x)) >> 30;
        term = odd ? x : Q30_ONE;
        sum  = longint'(term);
        n    = odd ? 1 : 0;
        for (int i = 0; i < 7; i++) begin
            term = series_div((term * x2) >> 30, n);
            if (i % 2 == 1) begin
                sum = sum + longint'(term);
            end else begin
                sum = sum - longint'(term);
            end
            n = n + 2;
        end
        return sum;
    endfunction

    function automatic logic [COS_W-1:0] cos_entry(input int k);
        longint quad;
        longint r;
        longint x;
        longint c;
        longint v;
        quad = (4 * k) / COS_TABLE_DEPTH;
        r    = (4 * k) % COS_TABLE_DEPTH;
        x    = (Q30_HALF_PI * r) / COS_TABLE_DEPTH;
        case (quad)
            0:       c =  taylor(x, 1'b0);
            1:       c = -taylor(x, 1'b1);
            2:       c = -taylor(x, 1'b0);
            default: c =  taylor(x, 1'b1);
        endcase
        if (c > Q30_ONE) begin
            c = Q30_ONE;
        end
        if (c < -Q30_ONE) begin
            c = -Q30_ONE;
        end
        v = (Q30_ONE + c + 64'sd16384) >>> 15;
        return v[COS_W-1:0];
    endfunction

    function automatic aet_cos_table_t build_cos_table();
        aet_cos_table_t tbl;
        for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
            tbl[k] = cos_entry(k);
        end
        return tbl;
    endfunction

endpackage

[design/aet_cos_rom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aet_cos_rom
// Raised-cosine ROM, 0.5 + 0.5*cos, Q16, registered read with enable.
// ----------------------------------------------------------------------------
module aet_cos_rom (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [aet_pkg::COS_AW-1:0] addr,
    output logic [aet_pkg::COS_W-1:0]  data
);
    import aet_pkg::*;

    localparam aet_cos_table_t COS_TABLE = build_cos_table();

    logic [COS_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= COS_TABLE[addr];
        end
    end

    assign data = data_reg;

endmodule

[design/amplitude_envelope_tremolo_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amplitude_envelope_tremolo_top
// Attack/sustain/decay envelope with cosine tremolo, fully pipelined.
// ----------------------------------------------------------------------------
// One time stamp is taken and one amplitude comes out per clock, in order,
// while the output is not stalled. The segment divider is a restoring divider
// with one quotient bit per stage over a 40-bit dividend; the tremolo gain
// (phase multiply, cosine ROM, depth multiply) runs alongside it, and the p1,
// p2, p3 and output stages apply the punch, the gain and the saturation. A
// stall on the output halts the pipe only while the stage in front of the
// output register holds a result. The cfg port is always ready; the user must
// write registers only while no beat is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module amplitude_envelope_tremolo_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [aet_pkg::TDATA_W-1:0]   s_tdata,   // [23:0] time_point
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [aet_pkg::TDATA_W-1:0]   m_tdata,   // [19:0] amplitude, [23:20] zero
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [aet_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aet_pkg::CFG_DAT_W-1:0] cfg_data
);
    import aet_pkg::*;

    localparam int NP = DIV_STEPS + 4;

    logic [TIME_W-1:0]         attack_reg, sustain_reg, decay_reg;
    logic signed [PUNCH_W-1:0] punch_reg;
    logic [DEPTH_W-1:0]        depth_reg;
    logic [RATE_W-1:0]         rate_reg;

    logic                      en;
    logic [NP-1:0]             vld_reg;
    aet_stage_t                st_reg  [DIV_STEPS+1];
    aet_stage_t                st_next [DIV_STEPS+1];
    logic [COS_W-1:0]          rom_c;

    logic [1:0]                p1_seg_reg;
    logic [QUO_W-1:0]          p1_q_reg;
    logic signed [PSUM_W-1:0]  p1_psum_reg;
    logic signed [GAIN_W-1:0]  p1_g_reg, p2_g_reg;
    logic signed [AMP_W-1:0]   p2_amp_reg, p2_amp_next;
    logic signed [PRODG_W-1:0] p3_prod_reg;
    logic signed [PRODG_W-1:0] p3_sh;
    logic                      m_tvalid_reg;
    logic [AMP_OUT_W-1:0]      m_amp_reg, m_amp_next;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg  <= '0;
            sustain_reg <= '0;
            decay_reg   <= '0;
            punch_reg   <= '0;
            depth_reg   <= '0;
            rate_reg    <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ATTACK:  attack_reg  <= cfg_data[TIME_W-1:0];
                REG_SUSTAIN: sustain_reg <= cfg_data[TIME_W-1:0];
                REG_DECAY:   decay_reg   <= cfg_data[TIME_W-1:0];
                REG_PUNCH:   punch_reg   <= cfg_data[PUNCH_W-1:0];
                REG_DEPTH:   depth_reg   <= cfg_data[DEPTH_W-1:0];
                REG_RATE:    rate_reg    <= cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // advance unless a result sits in front of a stalled output register
    assign en       = !vld_reg[NP-1] || !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[NP-2:0], s_tvalid};
            end
            if (!m_tvalid_reg || m_tready) begin
                m_tvalid_reg <= vld_reg[NP-1];
            end
        end
    end

    // ---------------- entry stage: segment select ----------------
    logic [TIME_W-1:0] t;
    logic [TIME_W:0]   as_sum, sus_left, dec_run;
    logic [TIME_W+RATE_W-1:0] t_rate;

    always_comb begin
        t        = s_tdata[TIME_W-1:0];
        as_sum   = {1'b0, attack_reg} + {1'b0, sustain_reg};
        sus_left = as_sum - {1'b0, t};
        dec_run  = {1'b0, t} - as_sum;
        t_rate   = t * rate_reg;

        st_next[0]       = '0;
        st_next[0].phase = t_rate[PHASE_W-1:0];
        if (t < attack_reg) begin
            st_next[0].seg = SEG_ATTACK;
            st_next[0].nq  = {4'b0, t, 12'b0};
            st_next[0].dvs = attack_reg;
        end else if ({1'b0, t} < as_sum) begin
            st_next[0].seg = SEG_SUSTAIN;
            st_next[0].nq  = {sus_left[TIME_W-1:0], 16'b0};
            st_next[0].dvs = sustain_reg;
        end else if (decay_reg == '0) begin
            st_next[0].seg = SEG_ZERO;
            st_next[0].nq  = '0;
            st_next[0].dvs = DVS_W'(1);
        end else begin
            st_next[0].seg = SEG_DECAY;
            st_next[0].nq  = {4'b0, dec_run[TIME_W-1:0], 12'b0};
            st_next[0].dvs = decay_reg;
        end
    end

    // ---------------- divider stages, tremolo alongside ----------------
    logic [PHASE_W+COS_CW-1:0] k_prod;
    logic [2*COS_W:0]          dc_sum;
    logic [GAIN_W:0]           g_wide;

    always_comb begin
        aet_div_t dstep;
        for (int j = 1; j <= DIV_STEPS; j++) begin
            st_next[j]     = st_reg[j-1];
            dstep          = div_step(st_reg[j-1].rem, st_reg[j-1].nq, st_reg[j-1].dvs);
            st_next[j].rem = dstep.rem;
            st_next[j].nq  = dstep.nq;
        end
        // phase to table address
        k_prod       = st_reg[0].phase * COS_CW'(COS_TABLE_DEPTH);
        st_next[1].k = k_prod[PHASE_W+COS_AW-1:PHASE_W];
        // gain = 1 - depth * c, rounded
        dc_sum = (2*COS_W+1)'(depth_reg) * (2*COS_W+1)'(rom_c) + (2*COS_W+1)'(32768);
        g_wide = (GAIN_W+1)'(65536) - dc_sum[2*COS_W:16];
        if (depth_reg == '0) begin
            st_next[3].g = GAIN_W'(65536);
        end else begin
            st_next[3].g = g_wide[GAIN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j <= DIV_STEPS; j++) begin
                st_reg[j] <= st_next[j];
            end
        end
    end

    aet_cos_rom u_rom (
        .aclk (aclk),
        .en   (en),
        .addr (st_reg[1].k),
        .data (rom_c)
    );

    // ---------------- post stages ----------------
    always_comb begin
        case (p1_seg_reg)
            SEG_ATTACK:  p2_amp_next = AMP_W'($signed({1'b0, p1_q_reg[11:0]}));
            SEG_SUSTAIN: p2_amp_next = AMP_W'(4096) + AMP_W'(p1_psum_reg >>> 16);
            SEG_DECAY:   p2_amp_next = AMP_W'(4096) - $signed({2'b0, p1_q_reg});
            default:     p2_amp_next = '0;
        endcase
        p3_sh = p3_prod_reg >>> 16;
        if (p3_sh > PRODG_W'(524287)) begin
            m_amp_next = AMP_OUT_W'(524287);
        end else if (p3_sh < -PRODG_W'(524288)) begin
            m_amp_next = AMP_OUT_W'(-524288);
        end else begin
            m_amp_next = p3_sh[AMP_OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_seg_reg  <= st_reg[DIV_STEPS].seg;
            p1_q_reg    <= st_reg[DIV_STEPS].nq[QUO_W-1:0];
            p1_psum_reg <= punch_reg * $signed({1'b0, st_reg[DIV_STEPS].nq[16:0]});
            p1_g_reg    <= st_reg[DIV_STEPS].g;
            p2_amp_reg  <= p2_amp_next;
            p2_g_reg    <= p1_g_reg;
            p3_prod_reg <= PRODG_W'(p2_amp_reg) * PRODG_W'(p2_g_reg);
        end
        if (!m_tvalid_reg || m_tready) begin
            m_amp_reg <= m_amp_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(TDATA_W-AMP_OUT_W)'(0), m_amp_reg};

endmodule

[design/aet_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aet_checker
// Port-level checks of the envelope/tremolo block, bound to the top level.
// ----------------------------------------------------------------------------
module aet_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [aet_pkg::TDATA_W-1:0]   m_tdata,
    input logic                          cfg_valid,
    input logic                          cfg_ready
);

    // hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed under stall");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:20] == 4'b0)
        else $error("tdata padding not zero");

    // an empty output register never blocks the input side
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // register writes are never held off
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("register write stalled");

endmodule

bind amplitude_envelope_tremolo_top aet_checker u_aet_checker (.*);
